// ===== rtl/pbrd_pkg.sv =====
// Shared types and constants of the PackBits row decoder.
// Stand-alone package; used by rtl/packbits_row_decoder.sv.
`default_nettype none

package pbrd_pkg;

  localparam int unsigned MaxRows     = 8192;
  localparam int unsigned MaxRowBytes = 16384;

  localparam int unsigned RowW    = $clog2(MaxRows);         // row index
  localparam int unsigned EntryW  = $clog2(MaxRows) + 1;     // entry counters, hold MaxRows
  localparam int unsigned ColW    = $clog2(MaxRowBytes) + 1; // column position, holds width
  localparam int unsigned ByteCntW = 16;                     // packed bytes of one row
  localparam int unsigned RowBytesW = 15;                    // row_bytes register
  localparam int unsigned RowCountW = 14;                    // row_count register
  localparam int unsigned OutColW = 14;                      // column field of a result
  localparam int unsigned LenW    = 8;

  // Register byte addresses, selected by paddr[2]
  localparam logic RegRowBytes = 1'b0;
  localparam logic RegRowCount = 1'b1;

  typedef enum logic [2:0] {
    PH_COUNT_HI = 3'b001,
    PH_COUNT_LO = 3'b010,
    PH_DECODE   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    RK_HEADER  = 3'b001,
    RK_LITERAL = 3'b010,
    RK_REPEAT  = 3'b100
  } run_kind_t;

  // One kept row: its index and its packed byte count
  typedef struct packed {
    logic [RowW-1:0]     row;
    logic [ByteCntW-1:0] count;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic             last;
    logic [LenW-1:0]  length;
    logic [7:0]       value;
    logic [OutColW-1:0] column;
    logic [RowW-1:0]  row;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/packbits_row_decoder.sv =====
// PackBits row decoder top level: row table, decode state, skid buffer; needs rtl/pbrd_pkg.sv.
// Results are registered: in the output register, or in the skid stage while the output stalls.
// Throughput: one input beat per cycle while the skid stage is empty; the row table is read one
//   entry ahead, so a row that ends on any byte hands over to the next row without a bubble.
// Reset (rst_n low, synchronous): decode returns to the first count byte, row_bytes = 1 and
//   row_count = 1; the row table is not cleared, it is only read after being written.
`default_nettype none

module packbits_row_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] data_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,    // [12:0] row, [26:13] column, [34:27] value,
                                         // [42:35] length, [47:43] zero
  output logic             out_tlast,    // last
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned RowW     = pbrd_pkg::RowW;
  localparam int unsigned EntryW   = pbrd_pkg::EntryW;
  localparam int unsigned ColW     = pbrd_pkg::ColW;
  localparam int unsigned ByteCntW = pbrd_pkg::ByteCntW;
  localparam int unsigned LenW     = pbrd_pkg::LenW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pbrd_pkg::RowBytesW-1:0] row_bytes_r;
  logic [pbrd_pkg::RowCountW-1:0] row_count_r;
  logic                           cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= pbrd_pkg::RowBytesW'(1);
      row_count_r <= pbrd_pkg::RowCountW'(1);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == pbrd_pkg::RegRowBytes) begin
        row_bytes_r <= cfg_pwdata[pbrd_pkg::RowBytesW-1:0];
      end else begin
        row_count_r <= cfg_pwdata[pbrd_pkg::RowCountW-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == pbrd_pkg::RegRowBytes) begin
      cfg_prdata = {{(32-pbrd_pkg::RowBytesW){1'b0}}, row_bytes_r};
    end else begin
      cfg_prdata = {{(32-pbrd_pkg::RowCountW){1'b0}}, row_count_r};
    end
  end

  // Clamp the registers into their usable ranges; taken fresh on every beat
  logic [ColW-1:0]   lim;
  logic [EntryW-1:0] eff_rows;

  always_comb begin
    priority if (row_bytes_r == '0) begin
      lim = ColW'(1);
    end else if (ColW'(row_bytes_r) > ColW'(pbrd_pkg::MaxRowBytes)) begin
      lim = ColW'(pbrd_pkg::MaxRowBytes);
    end else begin
      lim = ColW'(row_bytes_r);
    end
    priority if (row_count_r == '0) begin
      eff_rows = EntryW'(1);
    end else if (EntryW'(row_count_r) > EntryW'(pbrd_pkg::MaxRows)) begin
      eff_rows = EntryW'(pbrd_pkg::MaxRows);
    end else begin
      eff_rows = EntryW'(row_count_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Decode state
  // ---------------------------------------------------------------------------
  pbrd_pkg::phase_t    phase_r, phase_nxt;
  pbrd_pkg::run_kind_t run_kind_r, run_kind_nxt;
  logic [7:0]          count_high_r, count_high_nxt;
  logic [EntryW-1:0]   counts_read_r, counts_read_nxt;
  logic [EntryW-1:0]   rows_stored_r, rows_stored_nxt;
  logic [EntryW-1:0]   cur_entry_r, cur_entry_nxt;
  logic [ByteCntW-1:0] row_left_r, row_left_nxt;
  logic [ColW-1:0]     col_r, col_nxt;
  logic [LenW-1:0]     run_left_r, run_left_nxt;
  logic [RowW-1:0]     cur_row_r, cur_row_nxt;

  // Row table: one entry per kept row, read one entry ahead of the current one
  pbrd_pkg::entry_t    nz_mem [pbrd_pkg::MaxRows];
  pbrd_pkg::entry_t    rd_data_r, byp_data_r, wr_data, next_entry;
  pbrd_pkg::entry_t    entry0_r, entry0_nxt;
  logic                byp_r;
  logic                wr_en;
  logic [RowW-1:0]     wr_addr, rd_addr;

  logic                accept;
  logic                res_valid;
  pbrd_pkg::result_t   res;

  logic [7:0]          b;
  logic [ByteCntW-1:0] cnt;
  logic [EntryW-1:0]   cr_inc, ce_inc;
  logic [ByteCntW-1:0] row_left_dec;
  logic [ColW-1:0]     room;
  logic [LenW-1:0]     rep_len;
  logic [8:0]          rep_hdr;

  assign accept     = in_tvalid & in_tready;
  assign b          = in_tdata;
  assign cnt        = {count_high_r, b};
  assign cr_inc     = counts_read_r + EntryW'(1);
  assign ce_inc     = cur_entry_r + EntryW'(1);
  assign row_left_dec = (row_left_r != '0) ? row_left_r - ByteCntW'(1) : row_left_r;
  assign room       = lim - col_r;
  assign rep_len    = (ColW'(run_left_r) > room) ? room[LenW-1:0] : run_left_r;
  assign rep_hdr    = 9'd257 - {1'b0, b};
  assign next_entry = byp_r ? byp_data_r : rd_data_r;

  assign wr_addr     = rows_stored_r[RowW-1:0];
  assign wr_data.row = counts_read_r[RowW-1:0];
  assign wr_data.count = cnt;

  // Start of a new image: clear all but the registers, the table and the payload (cur_row, entry0)
  task automatic clear_image();
    phase_nxt       = pbrd_pkg::PH_COUNT_HI;
    count_high_nxt  = '0;
    counts_read_nxt = '0;
    rows_stored_nxt = '0;
    cur_entry_nxt   = '0;
    row_left_nxt    = '0;
    col_nxt         = '0;
    run_kind_nxt    = pbrd_pkg::RK_HEADER;
    run_left_nxt    = '0;
  endtask

  always_comb begin
    phase_nxt       = phase_r;
    run_kind_nxt    = run_kind_r;
    count_high_nxt  = count_high_r;
    counts_read_nxt = counts_read_r;
    rows_stored_nxt = rows_stored_r;
    cur_entry_nxt   = cur_entry_r;
    row_left_nxt    = row_left_r;
    col_nxt         = col_r;
    run_left_nxt    = run_left_r;
    cur_row_nxt     = cur_row_r;
    entry0_nxt      = entry0_r;
    wr_en           = 1'b0;
    res_valid       = 1'b0;
    res             = '0;

    if (accept) begin
      unique case (phase_r)
        pbrd_pkg::PH_COUNT_HI: begin
          count_high_nxt = b;
          phase_nxt      = pbrd_pkg::PH_COUNT_LO;
        end

        pbrd_pkg::PH_COUNT_LO: begin
          // Keep only rows with a nonzero byte count
          wr_en = (cnt != '0) && (rows_stored_r < EntryW'(pbrd_pkg::MaxRows));
          if (wr_en) begin
            rows_stored_nxt = rows_stored_r + EntryW'(1);
            if (rows_stored_r == '0) begin
              entry0_nxt = wr_data;
            end
          end
          counts_read_nxt = cr_inc;
          phase_nxt       = pbrd_pkg::PH_COUNT_HI;
          if (cr_inc >= eff_rows) begin
            if (rows_stored_nxt == '0) begin
              // Image without a single kept row: completion only
              res_valid = 1'b1;
              res.last  = 1'b1;
              clear_image();
            end else begin
              phase_nxt     = pbrd_pkg::PH_DECODE;
              cur_entry_nxt = '0;
              row_left_nxt  = entry0_nxt.count;
              cur_row_nxt   = entry0_nxt.row;
              col_nxt       = '0;
              run_kind_nxt  = pbrd_pkg::RK_HEADER;
              run_left_nxt  = '0;
            end
          end
        end

        pbrd_pkg::PH_DECODE: begin
          if (cur_entry_r >= rows_stored_r) begin
            clear_image();
          end else begin
            row_left_nxt = row_left_dec;
            res.row      = cur_row_r;
            res.column   = col_r[pbrd_pkg::OutColW-1:0];
            res.value    = b;
            // Bytes past the row width are skipped, headers included
            if (col_r < lim) begin
              unique case (run_kind_r)
                pbrd_pkg::RK_HEADER: begin
                  if (b < 8'd128) begin
                    run_kind_nxt = pbrd_pkg::RK_LITERAL;
                    run_left_nxt = b + 8'd1;
                  end else if (b != 8'd128) begin
                    run_kind_nxt = pbrd_pkg::RK_REPEAT;
                    run_left_nxt = rep_hdr[LenW-1:0];
                  end
                end
                pbrd_pkg::RK_LITERAL: begin
                  res_valid    = 1'b1;
                  res.length   = LenW'(1);
                  col_nxt      = col_r + ColW'(1);
                  run_left_nxt = (run_left_r != '0) ? run_left_r - LenW'(1) : run_left_r;
                  if (run_left_nxt == '0) begin
                    run_kind_nxt = pbrd_pkg::RK_HEADER;
                  end
                end
                pbrd_pkg::RK_REPEAT: begin
                  // Cut the run at the row width
                  res_valid    = 1'b1;
                  res.length   = rep_len;
                  col_nxt      = col_r + ColW'(rep_len);
                  run_left_nxt = '0;
                  run_kind_nxt = pbrd_pkg::RK_HEADER;
                end
                default: begin
                  run_kind_nxt = pbrd_pkg::RK_HEADER;
                end
              endcase
            end
            // Row's packed bytes used up: cut any open run, then next kept row or end of image
            if (row_left_dec == '0) begin
              cur_entry_nxt = ce_inc;
              col_nxt       = '0;
              run_kind_nxt  = pbrd_pkg::RK_HEADER;
              run_left_nxt  = '0;
              if (ce_inc >= rows_stored_r) begin
                if (!res_valid) begin
                  res       = '0;
                  res_valid = 1'b1;
                end
                res.last = 1'b1;
                clear_image();
              end else begin
                row_left_nxt = next_entry.count;
                cur_row_nxt  = next_entry.row;
              end
            end
          end
        end

        default: begin
          clear_image();
        end
      endcase
    end
  end

  // Read the entry after the one that will be current next cycle
  assign rd_addr = RowW'(cur_entry_nxt + EntryW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      nz_mem[wr_addr] <= wr_data;
    end
    rd_data_r  <= nz_mem[rd_addr];
    byp_r      <= wr_en && (wr_addr == rd_addr);
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= pbrd_pkg::PH_COUNT_HI;
      run_kind_r    <= pbrd_pkg::RK_HEADER;
      count_high_r  <= '0;
      counts_read_r <= '0;
      rows_stored_r <= '0;
      cur_entry_r   <= '0;
      row_left_r    <= '0;
      col_r         <= '0;
      run_left_r    <= '0;
    end else begin
      phase_r       <= phase_nxt;
      run_kind_r    <= run_kind_nxt;
      count_high_r  <= count_high_nxt;
      counts_read_r <= counts_read_nxt;
      rows_stored_r <= rows_stored_nxt;
      cur_entry_r   <= cur_entry_nxt;
      row_left_r    <= row_left_nxt;
      col_r         <= col_nxt;
      run_left_r    <= run_left_nxt;
    end
  end

  // Payload only: written before they are ever read
  always_ff @(posedge clk) begin
    cur_row_r <= cur_row_nxt;
    entry0_r  <= entry0_nxt;
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid stage: input closes while a second result waits
  // ---------------------------------------------------------------------------
  logic              out_valid_r, skid_valid_r;
  pbrd_pkg::result_t out_data_r, skid_data_r;
  logic              push;

  assign in_tready = ~skid_valid_r;
  assign push      = accept & res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      // Output slot frees up: move the skid beat forward, else the new one
      out_valid_r  <= skid_valid_r | push;
      skid_valid_r <= 1'b0;
    end else begin
      // Output stalled: park a new beat in the skid stage
      skid_valid_r <= skid_valid_r | push;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (push) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_data_r.length, out_data_r.value, out_data_r.column,
                       out_data_r.row};
  assign out_tlast  = out_data_r.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  a_decode_has_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == pbrd_pkg::PH_DECODE) |-> (rows_stored_r != '0))
    else $error("decoding an image without kept rows");

  a_open_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (run_kind_r != pbrd_pkg::RK_HEADER) |-> (run_left_r != '0))
    else $error("open run with no bytes left");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.length == '0)) |-> out_data_r.last)
    else $error("zero-length result that is not a completion");

endmodule

`default_nettype wire
